/* rtl/rms_envelope_follower_macros.svh */
// Assertion helpers used by rtl/rms_envelope_follower.sv.
// Both forms use the clk and rst_n names of the module that expands them.
`ifndef RMS_ENVELOPE_FOLLOWER_MACROS_SVH
`define RMS_ENVELOPE_FOLLOWER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RMSEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RMSEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMSEF_ASSERT_IMP(lbl, ante, cons, msg)
`define RMSEF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/rmsef_pkg.sv */
`default_nettype none

package rmsef_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 42;
  localparam int ENV_W     = 24;
  localparam int RMS_W     = 16;
  localparam int COEFF_W   = 17;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int TGT_W     = RMS_W + 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [RMS_W-1:0]   RMS_FULL      = 16'd32768;
  localparam logic [COEFF_W-1:0] ATTACK_RESET  = 17'd272;
  localparam logic [COEFF_W-1:0] RELEASE_RESET = 17'd14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIV,
    ST_SQRT,
    ST_ENV,
    ST_OUT
  } state_t;

  // Status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } step_sts_t;

endpackage

`default_nettype wire

/* rtl/rms_envelope_follower.sv */
`default_nettype none
// Sequence: a sample item holds in_tready low after its transfer while the
// bit-serial squarer runs and accumulates; no new sample is taken until it is done.
// A block-closing item then runs the divide, square root and envelope multiply and
// update, and loads the output register (once it is free) before out_tvalid rises.
// Reset (rst_n low, synchronous) clears the sum, count, overflow flag and
// envelope, sets the coefficients to 272 and 14 and empties the output register.

`include "rms_envelope_follower_macros.svh"

module rms_envelope_follower #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample
  input  logic                               in_tlast,
  input  logic                               in_tuser,   // [0] block_empty
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [39:0]                        out_tdata,  // [23:0] envelope, [39:24] blk_rms
  output logic                               out_tuser,  // [0] block_overflow
  input  logic                               cfg_we,
  input  logic [rmsef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmsef_pkg::COEFF_W-1:0]      cfg_wdata
);
  import rmsef_pkg::*;

  localparam int CntW = $clog2(MAX_BLOCK + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_BLOCK);

  state_t             state_r, state_nxt;
  logic               last_r;
  logic [COEFF_W-1:0] attack_r;
  logic [COEFF_W-1:0] release_r;
  logic               out_valid_r;
  logic [39:0]        out_data_r;
  logic               out_user_r;

  logic sq_start, sq_ovf, acc_clear, div_start, sqrt_start, env_start, out_load;
  logic in_xfer;

  logic [SUM_W-1:0]  sq_sum;
  logic [CntW-1:0]   sq_count;
  logic              sq_ovf_seen;
  logic [SUM_W-1:0]  quotient;
  logic [ROOT_W-1:0] root;
  logic [RMS_W-1:0]  rms;
  logic [ENV_W-1:0]  env_level;
  step_sts_t         sq_sts, div_sts, sqrt_sts, env_sts;

  assign in_xfer = in_tvalid && in_tready;

  // Clamp the root to full scale
  assign rms = (root > ROOT_W'(RMS_FULL)) ? RMS_FULL : root[RMS_W-1:0];

  rmsef_sqacc #(.CNT_W(CntW)) u_sqacc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .mark_ovf (sq_ovf),
    .clear    (acc_clear),
    .sample   (in_tdata),
    .sum      (sq_sum),
    .count    (sq_count),
    .ovf      (sq_ovf_seen),
    .sts      (sq_sts)
  );

  rmsef_div #(.CNT_W(CntW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sq_sum),
    .divisor  (sq_count),
    .quotient (quotient),
    .sts      (div_sts)
  );

  rmsef_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (quotient),
    .root     (root),
    .sts      (sqrt_sts)
  );

  rmsef_env u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (env_start),
    .target    ({rms, 9'b0}),
    .attack    (attack_r),
    .release_c (release_r),
    .level     (env_level),
    .sts       (env_sts)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the serial units
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    sq_start   = 1'b0;
    sq_ovf     = 1'b0;
    acc_clear  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    env_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (!in_tuser && (sq_count < MaxCount)) begin
            sq_start  = 1'b1;
            state_nxt = ST_SQ;
          end else begin
            sq_ovf = !in_tuser;
            if (in_tlast) begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_SQ: begin
        if (sq_sts.done) begin
          if (last_r) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_sts.done) begin
          env_start = 1'b1;
          state_nxt = ST_ENV;
        end
      end
      ST_ENV: begin
        if (env_sts.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          acc_clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the block marker of the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (in_xfer) begin
      last_r <= in_tlast;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RESET;
      release_r <= RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  attack_r  <= cfg_wdata;
        CFG_RELEASE: release_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Output register: load a result, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {rms, env_level};
      out_user_r <= sq_ovf_seen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `RMSEF_ASSERT_IMP(a_sq_busy_state, sq_sts.busy, state_r == ST_SQ, "squarer busy outside ST_SQ")
  `RMSEF_ASSERT_IMP(a_div_busy_state, div_sts.busy, state_r == ST_DIV, "divider busy outside ST_DIV")
  `RMSEF_ASSERT_IMP(a_sqrt_busy_state, sqrt_sts.busy, state_r == ST_SQRT, "root busy outside ST_SQRT")
  `RMSEF_ASSERT_IMP(a_count_bound, 1'b1, sq_count <= MaxCount, "sample count above block limit")
  `RMSEF_ASSERT_NXT(a_sample_return, sq_sts.done && !last_r, in_tready, "not ready after sample")

endmodule

`default_nettype wire

/* rtl/rmsef_sqacc.sv */
`default_nettype none

// Bit-serial squarer with a saturating sum of squares and a sample counter.
module rmsef_sqacc #(
  parameter int CNT_W = 13
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 mark_ovf,
  input  logic                                 clear,
  input  logic signed [rmsef_pkg::SAMPLE_W-1:0] sample,
  output logic [rmsef_pkg::SUM_W-1:0]          sum,
  output logic [CNT_W-1:0]                     count,
  output logic                                 ovf,
  output rmsef_pkg::step_sts_t                 sts
);
  import rmsef_pkg::*;

  localparam int ItW = $clog2(SAMPLE_W);
  localparam logic [ItW-1:0] ItLast = ItW'(SAMPLE_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [ItW-1:0]        it_r;
  logic [SAMPLE_W-1:0]   mcand_r;
  logic [2*SAMPLE_W-1:0] prod_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      count_r;
  logic                  ovf_r;

  logic [SAMPLE_W-1:0]   mag;
  logic [SAMPLE_W:0]     part;
  logic [2*SAMPLE_W-1:0] prod_nxt;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W-1:0]      sum_nxt;

  // Magnitude of the two's complement sample
  assign mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

  // One shift-add step, then the saturating accumulate on the last step
  always_comb begin
    part     = {1'b0, prod_r[2*SAMPLE_W-1:SAMPLE_W]}
             + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {part, prod_r[SAMPLE_W-1:1]};
    sum_add  = {1'b0, sum_r} + (SUM_W+1)'(prod_nxt);
    sum_nxt  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  end

  // Hold the iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      it_r    <= '0;
      sum_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (clear) begin
        sum_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (mark_ovf) begin
        ovf_r <= 1'b1;
      end
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == ItLast) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          sum_r   <= sum_nxt;
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  // Advance the multiplier datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mag;
      prod_r  <= {{SAMPLE_W{1'b0}}, mag};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign sum   = sum_r;
  assign count = count_r;
  assign ovf   = ovf_r;
  assign sts   = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* rtl/rmsef_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. A zero divisor gives zero.
module rmsef_div #(
  parameter int CNT_W = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rmsef_pkg::SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic [rmsef_pkg::SUM_W-1:0] quotient,
  output rmsef_pkg::step_sts_t        sts
);
  import rmsef_pkg::*;

  localparam int ItW = $clog2(SUM_W);
  localparam logic [ItW-1:0] ItLast = ItW'(SUM_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [ItW-1:0]   it_r;
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] dvsr_r;
  logic             zero_r;

  logic [CNT_W:0]   shifted;
  logic             ge;
  logic [CNT_W:0]   diff;
  logic [CNT_W-1:0] rem_nxt;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    ge      = shifted >= {1'b0, dvsr_r};
    diff    = shifted - {1'b0, dvsr_r};
    rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == ItLast) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = zero_r ? '0 : quo_r;
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* rtl/rmsef_isqrt.sv */
`default_nettype none

// Integer square root, one root bit (two radicand bits) per cycle.
module rmsef_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rmsef_pkg::SUM_W-1:0]  radicand,
  output logic [rmsef_pkg::ROOT_W-1:0] root,
  output rmsef_pkg::step_sts_t         sts
);
  import rmsef_pkg::*;

  localparam int ItW  = $clog2(ROOT_W);
  localparam int RemW = ROOT_W + 2;
  localparam int ShW  = ROOT_W + 3;
  localparam logic [ItW-1:0] ItLast = ItW'(ROOT_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [ItW-1:0]    it_r;
  logic [SUM_W-1:0]  v_r;
  logic [RemW-1:0]   rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [ShW-1:0]    rem_sh;
  logic [ShW-1:0]    trial;
  logic              ge;
  logic [ShW-1:0]    diff;
  logic [RemW-1:0]   rem_nxt;

  // Bring down two bits and test root*4+1
  always_comb begin
    rem_sh  = {rem_r[RemW-2:0], v_r[SUM_W-1:SUM_W-2]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = rem_sh >= trial;
    diff    = rem_sh - trial;
    rem_nxt = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == ItLast) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[SUM_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* rtl/rmsef_env.sv */
`default_nettype none

// Envelope update: serial coefficient multiply, rounding and clamped step.
module rmsef_env (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rmsef_pkg::TGT_W-1:0]   target,
  input  logic [rmsef_pkg::COEFF_W-1:0] attack,
  input  logic [rmsef_pkg::COEFF_W-1:0] release_c,
  output logic [rmsef_pkg::ENV_W-1:0]   level,
  output rmsef_pkg::step_sts_t          sts
);
  import rmsef_pkg::*;

  localparam int ProdW = TGT_W + COEFF_W;
  localparam int StepW = ProdW - 16;
  localparam int ItW   = $clog2(COEFF_W);
  localparam logic [ItW-1:0] ItLast = ItW'(COEFF_W - 1);
  localparam logic [ProdW-1:0] Half = ProdW'(32768);

  logic              busy_r;
  logic              done_r;
  logic              fin_r;
  logic [ItW-1:0]    it_r;
  logic [ENV_W-1:0]  level_r;
  logic              up_r;
  logic [TGT_W-1:0]  mag_r;
  logic [ProdW-1:0]  prod_r;

  logic [TGT_W-1:0]  level_x;
  logic              up;
  logic [COEFF_W-1:0] coeff;
  logic [TGT_W:0]    part;
  logic [ProdW-1:0]  prod_nxt;
  logic [ProdW-1:0]  rnd;
  logic [StepW-1:0]  step_v;
  logic [StepW:0]    raise;
  logic [ENV_W-1:0]  level_nxt;

  // Direction and coefficient for the step toward the target
  always_comb begin
    level_x = {1'b0, level_r};
    up      = target >= level_x;
    coeff   = (target > level_x) ? attack : release_c;
  end

  // One shift-add step of coeff * distance
  always_comb begin
    part     = {1'b0, prod_r[ProdW-1:COEFF_W]} + (prod_r[0] ? {1'b0, mag_r} : '0);
    prod_nxt = {part, prod_r[COEFF_W-1:1]};
  end

  // Round half up, then move the level and clamp to the Q0.24 range
  always_comb begin
    rnd    = prod_r + Half;
    step_v = rnd[ProdW-1:16];
    raise  = (StepW+1)'(level_r) + {1'b0, step_v};
    if (up) begin
      level_nxt = (raise > (StepW+1)'({ENV_W{1'b1}})) ? '1 : raise[ENV_W-1:0];
    end else begin
      level_nxt = (step_v >= StepW'(level_r)) ? '0 : level_r - step_v[ENV_W-1:0];
    end
    if (up_r) begin
      level_nxt = (raise > (StepW+1)'({ENV_W{1'b1}})) ? '1 : raise[ENV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      fin_r   <= 1'b0;
      it_r    <= '0;
      level_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
        it_r   <= '0;
      end else if (fin_r) begin
        fin_r   <= 1'b0;
        busy_r  <= 1'b0;
        done_r  <= 1'b1;
        level_r <= level_nxt;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == ItLast) begin
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Load the operands, then advance the product
  always_ff @(posedge clk) begin
    if (start) begin
      up_r   <= up;
      mag_r  <= up ? (target - level_x) : (level_x - target);
      prod_r <= {{TGT_W{1'b0}}, coeff};
    end else if (busy_r && !fin_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign level = level_r;
  assign sts   = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
  import rmsef_pkg::*;

  localparam int BLOCK_LIMIT   = 4096;
  localparam int SETTLE_CYCLES = 120;   // one sample item plus a full block close, with margin
  localparam int END_CYCLES    = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 110;

  localparam longint unsigned SUM_LIMIT = (64'd1 << 42) - 64'd1;
  localparam longint unsigned ENV_LIMIT = (64'd1 << 24) - 64'd1;

  typedef struct packed {
    logic [23:0] env;
    logic [15:0] rms;
    logic        ovf;
  } env_result_t;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [15:0]          smp;
    bit                   last;
    bit                   empty;
    bit                   typed;
    env_result_t          want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COEFF_W-1:0]   reg_val;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // [15:0] sample
  logic                 in_tlast   = 1'b0;
  logic                 in_tuser   = 1'b0; // [0] block_empty
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // [23:0] envelope, [39:24] blk_rms
  logic                 out_tuser;         // [0] block_overflow
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [COEFF_W-1:0]   cfg_wdata  = '0;

  // Tracker state: running block and envelope as the block should hold them
  logic [41:0]        sq_sum;
  logic [12:0]        smp_count;
  logic               ovf_flag;
  logic [23:0]        env_level;
  logic [COEFF_W-1:0] attack_k;
  logic [COEFF_W-1:0] release_k;

  env_result_t env_results_q[$];
  stim_row_t   dir_rows[$];
  int          n_errors;
  int          n_sent;
  bit          no_gaps;
  bit          hold_req;

  rms_envelope_follower #(.MAX_BLOCK(BLOCK_LIMIT)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor square root, one result bit per pass from the top
  function automatic logic [20:0] int_sqrt(input longint unsigned v);
    logic [20:0] root;
    logic [20:0] trial;
    root = '0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (21'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted item into the block; on block close queue the envelope result
  function automatic void absorb_sample(input logic [15:0] smp, input bit last,
                                        input bit empty, input bit typed,
                                        input env_result_t want);
    longint unsigned mag, sq, quo, rms, tgt, env, coef, delta, nxt;
    env_result_t got;
    if (!empty) begin
      if (smp_count < BLOCK_LIMIT) begin
        mag = smp[15] ? (64'd65536 - 64'(smp)) : 64'(smp);
        sq  = mag * mag;
        if (64'(sq_sum) > SUM_LIMIT - sq) sq_sum = SUM_LIMIT[41:0];
        else sq_sum = 42'(64'(sq_sum) + sq);
        smp_count++;
      end else begin
        ovf_flag = 1'b1;
      end
    end
    if (last) begin
      quo = (smp_count == 0) ? 64'd0 : 64'(sq_sum) / 64'(smp_count);
      rms = 64'(int_sqrt(quo));
      if (rms > 64'd32768) rms = 64'd32768;
      tgt  = rms << 9;
      env  = 64'(env_level);
      coef = (tgt > env) ? 64'(attack_k) : 64'(release_k);
      if (tgt >= env) begin
        delta = (coef * (tgt - env) + 64'd32768) >> 16;
        nxt   = env + delta;
        if (nxt > ENV_LIMIT) nxt = ENV_LIMIT;
      end else begin
        delta = (coef * (env - tgt) + 64'd32768) >> 16;
        nxt   = (delta >= env) ? 64'd0 : env - delta;
      end
      env_level = nxt[23:0];
      got.env = nxt[23:0];
      got.rms = rms[15:0];
      got.ovf = ovf_flag;
      env_results_q.push_back(typed ? want : got);
      sq_sum    = '0;
      smp_count = '0;
      ovf_flag  = 1'b0;
    end
  endfunction

  function automatic logic [15:0] pick_sample(input int shift);
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($signed(r) >>> shift);
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd7;
      2: return 17'd65536;
      3: return 17'h1FFFF;
      4: return ATTACK_RESET;
      5: return RELEASE_RESET;
      6: return 17'($urandom_range(7, 65536));
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic void row_item(input logic [15:0] smp, input bit last, input bit empty);
    stim_row_t r;
    r = '{kind: ROW_ITEM, smp: smp, last: last, empty: empty, typed: 1'b0,
          want: '0, reg_idx: '0, reg_val: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_check(input logic [15:0] smp, input bit last, input bit empty,
                                    input logic [23:0] env, input logic [15:0] rms,
                                    input logic ovf);
    stim_row_t r;
    r = '{kind: ROW_ITEM, smp: smp, last: last, empty: empty, typed: 1'b1,
          want: '0, reg_idx: '0, reg_val: '0};
    r.want.env = env;
    r.want.rms = rms;
    r.want.ovf = ovf;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COEFF_W-1:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, smp: '0, last: 1'b0, empty: 1'b0, typed: 1'b0,
          want: '0, reg_idx: idx, reg_val: val};
    dir_rows.push_back(r);
  endfunction

  // Offer one item, optionally after an idle burst, and hold it until the transfer
  task automatic send_item(input logic [15:0] smp, input bit last, input bit empty,
                           input bit typed = 1'b0, input env_result_t want = '0);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    in_tuser  <= empty;
    do @(posedge clk); while (!in_tready);
    absorb_sample(smp, last, empty, typed, want);
    n_sent++;
  endtask

  // Write a coefficient once the block has drained and settled
  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    in_tvalid <= 1'b0;
    while (env_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ATTACK) attack_k = val;
    else release_k = val;
  endtask

  // Result side: check each transfer, then pick the ready level for the next edge
  initial begin
    int gap_left;
    int hold_left;
    env_result_t want;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (env_results_q.size() == 0) begin
          n_errors++;
          $display("%0t: result with none pending: expected nothing, actual %h/%b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = env_results_q.pop_front();
          if (out_tdata[23:0] !== want.env) begin
            n_errors++;
            $display("%0t: envelope mismatch: expected %0d, actual %0d",
                     $time, want.env, out_tdata[23:0]);
          end
          if (out_tdata[39:24] !== want.rms) begin
            n_errors++;
            $display("%0t: rms mismatch: expected %0d, actual %0d",
                     $time, want.rms, out_tdata[39:24]);
          end
          if (out_tuser !== want.ovf) begin
            n_errors++;
            $display("%0t: block_overflow mismatch: expected %0d, actual %0d",
                     $time, want.ovf, out_tuser);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) stall = 0;
      else stall++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int goal;
    int blk_len;
    int shift;
    bit mark;

    sq_sum    = '0;
    smp_count = '0;
    ovf_flag  = 1'b0;
    env_level = '0;
    attack_k  = ATTACK_RESET;
    release_k = RELEASE_RESET;
    n_errors  = 0;
    n_sent    = 0;
    no_gaps   = 1'b0;
    hold_req  = 1'b0;

    // Directed table
    row_check(16'h0000, 1'b1, 1'b1, 24'd0, 16'd0, 1'b0);      // empty block after reset
    row_check(16'h0000, 1'b1, 1'b0, 24'd0, 16'd0, 1'b0);      // silent block
    row_item(16'h7FFF, 1'b0, 1'b0);                           // both sample extremes
    row_item(16'h8000, 1'b1, 1'b0);
    row_item(16'hFFFF, 1'b1, 1'b0);
    row_cfg(CFG_ATTACK, 17'd65536);
    row_check(16'h8000, 1'b1, 1'b0, 24'hFFFFFF, 16'd32768, 1'b0); // full-scale rms saturates the envelope
    row_cfg(CFG_RELEASE, 17'd65536);
    row_check(16'h0000, 1'b1, 1'b1, 24'd0, 16'd0, 1'b0);      // full release drops to zero
    row_cfg(CFG_ATTACK, 17'd7);
    row_cfg(CFG_RELEASE, 17'd7);
    row_check(16'h0001, 1'b1, 1'b0, 24'd0, 16'd1, 1'b0);      // step rounds to zero
    row_cfg(CFG_ATTACK, 17'h1FFFF);
    row_cfg(CFG_RELEASE, 17'h1FFFF);
    row_item(16'h4000, 1'b1, 1'b0);                           // overshooting attack
    row_check(16'h0000, 1'b1, 1'b0, 24'd0, 16'd0, 1'b0);      // overshooting release clamps
    row_cfg(CFG_ATTACK, 17'd0);
    row_check(16'h7FFF, 1'b1, 1'b0, 24'd0, 16'd32767, 1'b0);  // frozen envelope
    row_cfg(CFG_ATTACK, ATTACK_RESET);
    row_cfg(CFG_RELEASE, RELEASE_RESET);
    row_item(16'd1000, 1'b0, 1'b0);                           // empty marker inside a block
    row_item(16'd5, 1'b0, 1'b1);
    row_item(16'hFC18, 1'b1, 1'b0);
    row_item(16'd12345, 1'b1, 1'b1);                          // empty item closing the block
    row_item(16'd200, 1'b0, 1'b1);
    row_item(16'd300, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_coeff(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_item(dir_rows[i].smp, dir_rows[i].last, dir_rows[i].empty,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under a fresh pair of coefficients
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_coeff(CFG_ATTACK, pick_coeff());
      write_coeff(CFG_RELEASE, pick_coeff());
      if (ph == N_PHASES - 1) no_gaps = 1'b1;

      if (ph == 3) begin
        // hold the result side off while short blocks pile up behind it
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
          send_item(pick_sample($urandom_range(0, 15)), 1'b1, 1'b0);
        no_gaps = 1'b0;
      end

      goal = n_sent + PHASE_ITEMS;
      while (n_sent < goal) begin
        if ($urandom_range(0, 11) == 0) blk_len = 0;
        else if ($urandom_range(0, 7) == 0) blk_len = $urandom_range(9, 40);
        else blk_len = $urandom_range(1, 8);
        shift = $urandom_range(0, 15);
        if (blk_len == 0) begin
          send_item(16'($urandom), 1'b1, 1'b1);
        end else begin
          for (int k = 0; k < blk_len; k++) begin
            mark = ($urandom_range(0, 9) == 0);
            send_item(pick_sample(shift), k == blk_len - 1, mark);
          end
        end
      end
    end

    // Drain and let the block settle
    in_tvalid <= 1'b0;
    while (env_results_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/rmsef_pkg.sv
rtl/rmsef_sqacc.sv
rtl/rmsef_div.sv
rtl/rmsef_isqrt.sv
rtl/rmsef_env.sv
rtl/rms_envelope_follower.sv
verif/tb_top.sv
